FILE: rtl/hgc_pkg.sv
// Shared types, constants and decode tables for the Hangul glyph composer.
package hgc_pkg;

  localparam int FONT_GLYPHS_DEF = 360;
  localparam int KS_ENTRIES_DEF  = 2350;
  localparam int GLYPH_BYTES     = 32;
  localparam int GLYPH_W         = 9;
  localparam int IDX_W           = 5;

  localparam logic [1:0] ACT_LOAD_FONT = 2'd0;
  localparam logic [1:0] ACT_LOAD_KS   = 2'd1;
  localparam logic [1:0] ACT_COMPOSE   = 2'd2;

  localparam logic [16:0] KS_HI_BASE = 17'h000B0;
  localparam logic [16:0] KS_ROW     = 17'd94;
  localparam logic [16:0] KS_LO_BASE = 17'h000A1;

  localparam logic [GLYPH_W-1:0] JUNG_BASE    = 9'd160;
  localparam logic [GLYPH_W-1:0] JONG_BASE    = 9'd248;
  localparam logic [7:0]         ISET_OPEN0   = 8'(1 * 20);
  localparam logic [7:0]         ISET_CLOSED0 = 8'(6 * 20);
  localparam logic [6:0]         FSET_BARE    = 7'(1 * 28);
  localparam logic [6:0]         MSET_OPEN    = 7'd22;
  localparam logic [6:0]         MSET_CL_A    = 7'd44;
  localparam logic [6:0]         MSET_CL_B    = 7'd66;
  localparam logic [4:0]         INI_GA2      = 5'd1;
  localparam logic [4:0]         INI_KA       = 5'd16;

  localparam logic [4:0] MAP_INIT [32] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

  localparam logic [4:0] MAP_MED [32] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd0, 5'd0, 5'd6, 5'd7,
    5'd8, 5'd9, 5'd10, 5'd11, 5'd0, 5'd0, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd16, 5'd17, 5'd0, 5'd0, 5'd18, 5'd19, 5'd20, 5'd21, 5'd0, 5'd0};

  localparam logic [4:0] MAP_FIN [32] = '{
    5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
    5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd0, 5'd17, 5'd18, 5'd19,
    5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd0, 5'd0};

  localparam logic [7:0] SET_INIT_OPEN [32] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd20, 8'd60,
    8'd60, 8'd60, 8'd20, 8'd40, 8'd80, 8'd80, 8'd80, 8'd40, 8'd20, 8'd60,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [7:0] SET_INIT_CLOSED [32] = '{
    8'd0, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100, 8'd100,
    8'd120, 8'd140, 8'd140, 8'd140, 8'd120, 8'd120, 8'd140, 8'd140, 8'd140,
    8'd120, 8'd120, 8'd140, 8'd100,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

  localparam logic [6:0] SET_FIN [32] = '{
    7'd0, 7'd0, 7'd56, 7'd0, 7'd56, 7'd28, 7'd56, 7'd28, 7'd56, 7'd84, 7'd0,
    7'd56, 7'd28, 7'd84, 7'd84, 7'd28, 7'd56, 7'd28, 7'd84, 7'd84, 7'd28,
    7'd28, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};

  typedef struct packed {
    logic [GLYPH_W-1:0] ini_glyph;
    logic [GLYPH_W-1:0] med_glyph;
    logic [GLYPH_W-1:0] fin_glyph;
    logic               has_fin;
  } glyph_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KS_READ,
    ST_DECODE,
    ST_RD_INI,
    ST_RD_MED,
    ST_RD_FIN,
    ST_PUT,
    ST_BAD
  } state_t;

endpackage

FILE: rtl/hgc_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module hgc_ram
  import hgc_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/hgc_code_split.sv
// Splits a johab code into the glyph numbers of its initial, medial and final parts.
module hgc_code_split
  import hgc_pkg::*;
(
  input  logic [15:0] code,
  output glyph_sel_t  sel
);

  logic [4:0] ini;
  logic [4:0] med;
  logic [4:0] fin;
  logic [7:0] iset;
  logic [6:0] mset;
  logic [6:0] fset;
  logic       ini_round;

  always_comb begin
    ini       = MAP_INIT[code[14:10]];
    med       = MAP_MED[code[9:5]];
    fin       = MAP_FIN[code[4:0]];
    ini_round = (ini == INI_GA2) || (ini == INI_KA);
    fset      = '0;
    if (fin == '0) begin
      if (med == '0) begin
        iset = ISET_OPEN0;
        mset = '0;
      end else begin
        iset = SET_INIT_OPEN[med];
        mset = ini_round ? '0 : MSET_OPEN;
      end
    end else begin
      if (med == '0) begin
        iset = ISET_CLOSED0;
        mset = '0;
        fset = FSET_BARE;
      end else begin
        iset = SET_INIT_CLOSED[med];
        mset = ini_round ? MSET_CL_A : MSET_CL_B;
        fset = SET_FIN[med];
      end
    end
    sel.ini_glyph = GLYPH_W'(iset) + GLYPH_W'(ini);
    sel.med_glyph = JUNG_BASE + GLYPH_W'(mset) + GLYPH_W'(med);
    sel.has_fin   = (fin != '0);
    // no final: park the read on glyph zero, its data is masked
    sel.fin_glyph = sel.has_fin ? (JONG_BASE + GLYPH_W'(fset) + GLYPH_W'(fin)) : '0;
  end

endmodule

FILE: rtl/hangul_glyph_composer_unit.sv
// Top level of the Hangul glyph composer: control sequencer, memories and ports.
// Sequence: a compose passes DECODE (after KS_READ in KS mode), then RD_INI, RD_MED,
// RD_FIN and PUT for each glyph word, bound by the single font read port (three reads
// per word plus the output hand-off); PUT waits while the output is stalled. The input
// stays closed until a glyph or a bad KS code is fully sent; loads and unused actions do not.
// Reset: synchronous; clears the sequencer, the output register and ks_input_mode.
// The font store and conversion table are not cleared and need no clearing pass.
module hangul_glyph_composer_unit
  import hgc_pkg::*;
#(
  parameter int FONT_GLYPHS = FONT_GLYPHS_DEF,
  parameter int KS_ENTRIES  = KS_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // load_addr[13:0], load_data[29:14], char_code[45:30]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // glyph_byte[7:0], byte_index[12:8]
  output logic        m_axis_tlast,  // last_byte
  output logic [0:0]  m_axis_tuser,  // bad_code[0]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FONT_BYTES = FONT_GLYPHS * GLYPH_BYTES;
  localparam int FONT_AW    = $clog2(FONT_BYTES);
  localparam int KS_AW      = $clog2(KS_ENTRIES);

  // ---------------------------------------------------------------------------
  // Input word fields
  // ---------------------------------------------------------------------------
  logic [1:0]  in_action;
  logic [13:0] in_load_addr;
  logic [15:0] in_load_data;
  logic [15:0] in_char_code;
  logic        in_accept;

  assign in_action    = s_axis_tuser;
  assign in_load_addr = s_axis_tdata[13:0];
  assign in_load_data = s_axis_tdata[29:14];
  assign in_char_code = s_axis_tdata[45:30];
  assign in_accept    = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Configuration register: one bit at byte address 0
  // ---------------------------------------------------------------------------
  logic ks_input_mode;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_input_mode <= 1'b0;
    end else if (cfg_write && (paddr[2] == 1'b0)) begin
      ks_input_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {31'd0, ks_input_mode} : 32'd0;

  // ---------------------------------------------------------------------------
  // KS table index: (high - 0xB0) * 94 + low - 0xA1, signed so both ends can be checked
  // ---------------------------------------------------------------------------
  logic signed [16:0] ks_row;
  logic signed [16:0] ks_idx;
  logic               ks_bad;

  always_comb begin
    ks_row = $signed({9'd0, in_char_code[15:8]}) - $signed(KS_HI_BASE);
    ks_idx = ks_row * $signed(KS_ROW) + $signed({9'd0, in_char_code[7:0]})
             - $signed(KS_LO_BASE);
    ks_bad = (ks_idx < 0) || (ks_idx >= $signed(17'(KS_ENTRIES)));
  end

  // ---------------------------------------------------------------------------
  // Memories. Writes happen only on load actions accepted while idle, reads only for a
  // compose, so an access to the same entry can never overlap and no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic               font_we;
  logic               font_re;
  logic [FONT_AW-1:0] font_raddr;
  logic [7:0]         font_rdata;
  logic               ks_we;
  logic               ks_re;
  logic [15:0]        ks_rdata;

  assign font_we = in_accept && (in_action == ACT_LOAD_FONT)
                   && (32'(in_load_addr) < FONT_BYTES);
  assign ks_we   = in_accept && (in_action == ACT_LOAD_KS)
                   && (32'(in_load_addr) < KS_ENTRIES);

  hgc_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES),
    .AW    (FONT_AW)
  ) u_font_store (
    .clk   (clk),
    .we    (font_we),
    .waddr (in_load_addr[FONT_AW-1:0]),
    .wdata (in_load_data[7:0]),
    .re    (font_re),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  hgc_ram #(
    .WIDTH (16),
    .DEPTH (KS_ENTRIES),
    .AW    (KS_AW)
  ) u_ks_table (
    .clk   (clk),
    .we    (ks_we),
    .waddr (in_load_addr[KS_AW-1:0]),
    .wdata (in_load_data),
    .re    (ks_re),
    .raddr (ks_idx[KS_AW-1:0]),
    .rdata (ks_rdata)
  );

  // ---------------------------------------------------------------------------
  // Code decode: registered once per glyph
  // ---------------------------------------------------------------------------
  logic [15:0] code;
  glyph_sel_t  sel_comb;
  glyph_sel_t  sel;

  hgc_code_split u_split (
    .code (code),
    .sel  (sel_comb)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_t         state;
  state_t         state_next;
  logic [IDX_W-1:0] byte_cnt;
  logic [7:0]     acc;
  logic [7:0]     put_byte;
  logic           slot_free;
  logic           out_load;
  logic           byte_last;
  logic           is_compose;

  logic           out_valid;
  logic [7:0]     out_byte;
  logic [IDX_W-1:0] out_idx;
  logic           out_last;
  logic           out_bad;

  assign slot_free  = !out_valid || m_axis_tready;
  assign byte_last  = (byte_cnt == IDX_W'(GLYPH_BYTES - 1));
  assign is_compose = in_accept && (in_action == ACT_COMPOSE);
  // read data of the final is held since its read, so PUT may wait freely
  assign put_byte   = acc | (sel.has_fin ? font_rdata : 8'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_compose) begin
          if (!ks_input_mode) begin
            state_next = ST_DECODE;
          end else if (ks_bad) begin
            state_next = ST_BAD;
          end else begin
            state_next = ST_KS_READ;
          end
        end
      end
      ST_KS_READ: state_next = ST_DECODE;
      ST_DECODE:  state_next = ST_RD_INI;
      ST_RD_INI:  state_next = ST_RD_MED;
      ST_RD_MED:  state_next = ST_RD_FIN;
      ST_RD_FIN:  state_next = ST_PUT;
      ST_PUT: begin
        if (slot_free) begin
          state_next = byte_last ? ST_IDLE : ST_RD_INI;
        end
      end
      ST_BAD: begin
        if (slot_free && byte_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    font_re       = 1'b0;
    font_raddr    = '0;
    ks_re         = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ks_re         = is_compose && ks_input_mode;
      end
      ST_RD_INI: begin
        font_re    = 1'b1;
        font_raddr = FONT_AW'({sel.ini_glyph, byte_cnt});
      end
      ST_RD_MED: begin
        font_re    = 1'b1;
        font_raddr = FONT_AW'({sel.med_glyph, byte_cnt});
      end
      ST_RD_FIN: begin
        font_re    = 1'b1;
        font_raddr = FONT_AW'({sel.fin_glyph, byte_cnt});
      end
      ST_PUT:  out_load = slot_free;
      ST_BAD:  out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      code     <= in_char_code;
      byte_cnt <= '0;
    end
    if (state == ST_KS_READ) begin
      code <= ks_rdata;
    end
    if (state == ST_DECODE) begin
      sel <= sel_comb;
    end
    if (state == ST_RD_MED) begin
      acc <= font_rdata;
    end
    if (state == ST_RD_FIN) begin
      acc <= acc | font_rdata;
    end
    if (out_load) begin
      byte_cnt <= byte_cnt + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: parts the sequencer from the output stream
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= (state == ST_BAD) ? 8'd0 : put_byte;
      out_idx  <= byte_cnt;
      out_last <= byte_last;
      out_bad  <= (state == ST_BAD);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'd0, out_idx, out_byte};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_bad;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[12:8] == 5'd31)))
    else $error("last flag does not match byte position");

  a_bad_is_blank: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("bad code word carries glyph data");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (font_we || ks_we) |-> (state == ST_IDLE))
    else $error("memory written while a glyph is composed");

  a_idx_advance: assert property (@(posedge clk) disable iff (rst)
    (out_load && !byte_last) |=> (byte_cnt == $past(byte_cnt) + 1'b1))
    else $error("byte counter failed to advance");

endmodule
